// File: hw/rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// Sine PWM sequencer package
// Shared widths, register indexes, sector codes and transaction types.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int DATA_W      = 8;
	localparam int SECTOR_W    = 2;
	localparam int CFG_ADDR_W  = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_ADDR_W-1:0] REG_DEAD_TIME     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_POSITION_STEP = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_PRESCALE      = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_REVERSE       = 3'd4;

	localparam logic [DATA_W-1:0] RST_DEAD_TIME     = 8'd10;
	localparam logic [DATA_W-1:0] RST_POSITION_STEP = 8'd1;
	localparam logic [DATA_W-1:0] RST_AMPLITUDE     = 8'd80;
	localparam logic [DATA_W-1:0] RST_PRESCALE      = 8'd8;
	localparam logic              RST_REVERSE       = 1'b0;

	localparam logic [SECTOR_W-1:0] SECTOR_0 = 2'd0;
	localparam logic [SECTOR_W-1:0] SECTOR_1 = 2'd1;
	localparam logic [SECTOR_W-1:0] SECTOR_2 = 2'd2;
	localparam logic [SECTOR_W-1:0] SECTOR_BAD = 2'd3;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] dead_time;
		logic [DATA_W-1:0] position_step;
		logic [DATA_W-1:0] amplitude;
		logic [DATA_W-1:0] prescale;
		logic              reverse;
	} cfg_t;

	typedef struct packed {
		logic                kind;
		logic [TABLE_AW-1:0] addr;
		logic [DATA_W-1:0]   value;
		logic [SECTOR_W-1:0] sector;
		logic                commuted;
	} job_t;

endpackage

// File: hw/rtl/sps_if.sv
// ----------------------------------------------------------------------------
// Sine PWM sequencer channels
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sps_req_if;
	import sps_pkg::*;
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [TABLE_AW-1:0] table_index;
	logic [DATA_W-1:0]   table_value;
	modport source (output valid, req_type, table_index, table_value, input ready);
	modport sink (input valid, req_type, table_index, table_value, output ready);
endinterface

interface sps_rsp_if;
	import sps_pkg::*;
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   phase_a_high;
	logic [DATA_W-1:0]   phase_a_low;
	logic [DATA_W-1:0]   phase_b_high;
	logic [DATA_W-1:0]   phase_b_low;
	logic [DATA_W-1:0]   phase_c_high;
	logic [DATA_W-1:0]   phase_c_low;
	logic [SECTOR_W-1:0] sector;
	logic                commuted;
	modport source (output valid, phase_a_high, phase_a_low, phase_b_high, phase_b_low,
		phase_c_high, phase_c_low, sector, commuted, input ready);
	modport sink (input valid, phase_a_high, phase_a_low, phase_b_high, phase_b_low,
		phase_c_high, phase_c_low, sector, commuted, output ready);
endinterface

interface sps_cfg_if;
	import sps_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [DATA_W-1:0]     data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// File: hw/rtl/sps_front.sv
// ----------------------------------------------------------------------------
// Sine PWM sequencer front end
// Accepts requests, runs prescaler, position and sector, emits jobs.
// ----------------------------------------------------------------------------
module sps_front (
	input  logic           clk,
	input  logic           arst_n,
	sps_req_if.sink        req,
	input  sps_pkg::cfg_t  cfg,
	output logic           push_valid,
	input  logic           push_ready,
	output sps_pkg::job_t  push_data
);
	import sps_pkg::*;

	logic [DATA_W-1:0]   tick_count_q;
	logic [DATA_W-1:0]   position_q;
	logic [SECTOR_W-1:0] sector_q;

	logic                accept;
	logic                tick;
	logic [DATA_W-1:0]   tick_inc;
	logic                advance;
	logic [DATA_W-1:0]   pos_sum;
	logic                wrap;
	logic [SECTOR_W-1:0] sector_fwd;
	logic [SECTOR_W-1:0] sector_rev;
	logic [DATA_W-1:0]   tick_next;
	logic [DATA_W-1:0]   pos_next;
	logic [SECTOR_W-1:0] sector_next;

	assign accept     = req.valid && req.ready;
	assign tick       = (req.req_type == REQ_TICK);
	assign req.ready  = push_ready;
	assign push_valid = req.valid;

	assign tick_inc = tick_count_q + 8'd1;
	assign advance  = (tick_inc >= cfg.prescale);
	assign pos_sum  = position_q + cfg.position_step;
	assign wrap     = advance && (pos_sum < cfg.position_step);

	always_comb begin
		case (sector_q)
			SECTOR_0: begin
				sector_fwd = SECTOR_1;
				sector_rev = SECTOR_2;
			end
			SECTOR_1: begin
				sector_fwd = SECTOR_2;
				sector_rev = SECTOR_0;
			end
			SECTOR_2: begin
				sector_fwd = SECTOR_0;
				sector_rev = SECTOR_1;
			end
			default: begin
				sector_fwd = SECTOR_1;
				sector_rev = SECTOR_2;
			end
		endcase
	end

	always_comb begin
		tick_next   = advance ? '0 : tick_inc;
		pos_next    = advance ? pos_sum : position_q;
		sector_next = sector_q;
		if (wrap) begin
			sector_next = cfg.reverse ? sector_rev : sector_fwd;
		end
	end

	always_comb begin
		push_data.kind = req.req_type;
		if (tick) begin
			push_data.addr     = pos_next;
			push_data.value    = '0;
			push_data.sector   = sector_next;
			push_data.commuted = wrap;
		end else begin
			push_data.addr     = req.table_index;
			push_data.value    = req.table_value;
			push_data.sector   = sector_q;
			push_data.commuted = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			position_q   <= '0;
			sector_q     <= SECTOR_0;
		end else if (accept && tick) begin
			tick_count_q <= tick_next;
			position_q   <= pos_next;
			sector_q     <= sector_next;
		end
	end

`ifndef SYNTH
	a_load_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !tick |=> $stable(position_q) && $stable(tick_count_q) && $stable(sector_q))
		else $error("load changed sequencer state");
	a_wrap_rotates: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tick && wrap |=> sector_q != $past(sector_q))
		else $error("wrap did not rotate sector");
	a_sector_legal: assert property (@(posedge clk) disable iff (!arst_n)
		sector_q != SECTOR_BAD)
		else $error("sector out of range");
`endif
endmodule

// File: hw/rtl/sps_queue.sv
// ----------------------------------------------------------------------------
// Sine PWM sequencer job queue
// Small FIFO between front end and back end.
// ----------------------------------------------------------------------------
module sps_queue #(
	parameter int DEPTH = sps_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  sps_pkg::job_t  push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output sps_pkg::job_t  pop_data
);
	import sps_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("queue count overflow");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow");
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not shrink");
`endif
endmodule

// File: hw/rtl/sps_back.sv
// ----------------------------------------------------------------------------
// Sine PWM sequencer back end
// Holds the sine table, scales both words and forms the compare values.
// ----------------------------------------------------------------------------
module sps_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sps_pkg::cfg_t  cfg,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  sps_pkg::job_t  pop_data,
	sps_rsp_if.source      rsp
);
	import sps_pkg::*;

	logic [DATA_W-1:0] table_mem [TABLE_DEPTH];

	logic                adv;
	logic                pop;
	logic                v_s1;
	logic                v_s2;
	logic                v_out_q;
	logic [DATA_W-1:0]   word_p_s1;
	logic [DATA_W-1:0]   word_m_s1;
	logic [SECTOR_W-1:0] sector_s1;
	logic                commuted_s1;
	logic [DATA_W-1:0]   drv_s2;
	logic [DATA_W-1:0]   trl_s2;
	logic [SECTOR_W-1:0] sector_s2;
	logic                commuted_s2;
	logic [DATA_W-1:0]   drv_word;
	logic [DATA_W-1:0]   trl_word;
	logic [2*DATA_W-1:0] drv_prod;
	logic [2*DATA_W-1:0] trl_prod;
	logic [DATA_W-1:0]   ph_a;
	logic [DATA_W-1:0]   ph_b;
	logic [DATA_W-1:0]   ph_c;
	logic [DATA_W-1:0]   a_high_q;
	logic [DATA_W-1:0]   a_low_q;
	logic [DATA_W-1:0]   b_high_q;
	logic [DATA_W-1:0]   b_low_q;
	logic [DATA_W-1:0]   c_high_q;
	logic [DATA_W-1:0]   c_low_q;
	logic [SECTOR_W-1:0] sector_q;
	logic                commuted_q;

	assign adv       = !v_out_q || rsp.ready;
	assign pop_ready = adv;
	assign pop       = pop_valid && adv;

	always_ff @(posedge clk) begin
		if (pop && pop_data.kind == REQ_LOAD) begin
			table_mem[pop_data.addr] <= pop_data.value;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_p_s1   <= table_mem[pop_data.addr];
			word_m_s1   <= table_mem[~pop_data.addr];
			sector_s1   <= pop_data.sector;
			commuted_s1 <= pop_data.commuted;
		end
	end

	assign drv_word = cfg.reverse ? word_m_s1 : word_p_s1;
	assign trl_word = cfg.reverse ? word_p_s1 : word_m_s1;
	assign drv_prod = cfg.amplitude * drv_word;
	assign trl_prod = cfg.amplitude * trl_word;

	always_ff @(posedge clk) begin
		if (adv) begin
			drv_s2      <= drv_prod[2*DATA_W-1:DATA_W];
			trl_s2      <= trl_prod[2*DATA_W-1:DATA_W];
			sector_s2   <= sector_s1;
			commuted_s2 <= commuted_s1;
		end
	end

	always_comb begin
		case (sector_s2)
			SECTOR_1: begin
				ph_a = trl_s2;
				ph_b = drv_s2;
				ph_c = '0;
			end
			SECTOR_2: begin
				ph_a = '0;
				ph_b = trl_s2;
				ph_c = drv_s2;
			end
			default: begin
				ph_a = drv_s2;
				ph_b = '0;
				ph_c = trl_s2;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_high_q   <= ph_a + cfg.dead_time;
			a_low_q    <= ph_a;
			b_high_q   <= ph_b + cfg.dead_time;
			b_low_q    <= ph_b;
			c_high_q   <= ph_c + cfg.dead_time;
			c_low_q    <= ph_c;
			sector_q   <= sector_s2;
			commuted_q <= commuted_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_out_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= pop && (pop_data.kind == REQ_TICK);
			v_s2    <= v_s1;
			v_out_q <= v_s2;
		end
	end

	assign rsp.valid        = v_out_q;
	assign rsp.phase_a_high = a_high_q;
	assign rsp.phase_a_low  = a_low_q;
	assign rsp.phase_b_high = b_high_q;
	assign rsp.phase_b_low  = b_low_q;
	assign rsp.phase_c_high = c_high_q;
	assign rsp.phase_c_low  = c_low_q;
	assign rsp.sector       = sector_q;
	assign rsp.commuted     = commuted_q;

`ifndef SYNTH
	a_out_sector_legal: assert property (@(posedge clk) disable iff (!arst_n)
		v_out_q |-> sector_q != SECTOR_BAD)
		else $error("result sector out of range");
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && pop_data.kind == REQ_LOAD |=> !v_s1)
		else $error("load produced a result");
	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_s2) && $stable(v_out_q))
		else $error("pipeline moved during stall");
`endif
endmodule

// File: hw/rtl/three_phase_sine_pwm_sequencer_top.sv
// ----------------------------------------------------------------------------
// Three-phase sine PWM sequencer
// Table load and timer tick requests in, six compare values per tick out.
// ----------------------------------------------------------------------------
// Accepts one request per clock while the result side keeps up; a tick's
// result passes the queue, the table read, the scale multiply and the
// compare register. A load writes one sine table word and gives no result.
// The sine table has no reset; load every entry a tick can reach before
// sending ticks. Configuration writes take effect on the next request. The
// user must make them only while the block is idle; it is not enforced.
module three_phase_sine_pwm_sequencer_top #(
	parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	sps_req_if.sink   req,
	sps_rsp_if.source rsp,
	sps_cfg_if.sink   cfg
);
	import sps_pkg::*;

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic pop_valid;
	logic pop_ready;
	job_t pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_time     <= RST_DEAD_TIME;
			cfg_q.position_step <= RST_POSITION_STEP;
			cfg_q.amplitude     <= RST_AMPLITUDE;
			cfg_q.prescale      <= RST_PRESCALE;
			cfg_q.reverse       <= RST_REVERSE;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				REG_DEAD_TIME:     cfg_q.dead_time     <= cfg.data;
				REG_POSITION_STEP: cfg_q.position_step <= cfg.data;
				REG_AMPLITUDE:     cfg_q.amplitude     <= cfg.data;
				REG_PRESCALE:      cfg_q.prescale      <= cfg.data;
				REG_REVERSE:       cfg_q.reverse       <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	sps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Three-phase sine PWM sequencer testbench
// Fills the sine table, runs a directed table of loads, ticks and register
// writes, then random phases of ticks and loads under several register
// settings. Every tick result is checked field by field against an in-order
// model prediction or typed row values, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
	import sps_pkg::*;

	localparam int LIMIT_NS       = 2_000_000;
	localparam int SETTLE_CYC     = 16;
	localparam int RAND_PHASES    = 8;
	localparam int ITEMS_PER_PHASE = 60;
	localparam int DIR_ROWS       = 27;
	localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = REG_REVERSE + 3'd1;

	typedef struct packed {
		logic [DATA_W-1:0]   a_high;
		logic [DATA_W-1:0]   a_low;
		logic [DATA_W-1:0]   b_high;
		logic [DATA_W-1:0]   b_low;
		logic [DATA_W-1:0]   c_high;
		logic [DATA_W-1:0]   c_low;
		logic [SECTOR_W-1:0] sector;
		logic                commuted;
	} pwm_out_t;

	typedef enum logic [1:0] {ROW_LOAD, ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_ADDR_W-1:0] addr;
		logic [DATA_W-1:0]     index;
		logic [DATA_W-1:0]     value;
		bit                    typed;
		pwm_out_t              want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sps_req_if req_ch ();
	sps_rsp_if rsp_ch ();
	sps_cfg_if cfg_ch ();

	three_phase_sine_pwm_sequencer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cfg_t              shadow_cfg;
	logic [DATA_W-1:0] sine_mem [TABLE_DEPTH];
	logic [DATA_W-1:0] tick_cnt;
	logic [DATA_W-1:0] pos;
	logic [SECTOR_W-1:0] sect;

	pwm_out_t compare_q [$];
	pwm_out_t got_want;
	int       err_cnt = 0;
	int       stall_left = 0;
	bit       calm = 1'b0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_LOAD, '0, 8'd0, 8'd0, 1'b0, '0},
		'{ROW_LOAD, '0, 8'd255, 8'd0, 1'b0, '0},
		'{ROW_TICK, '0, 8'd0, 8'd0, 1'b1,
			'{8'd10, 8'd0, 8'd10, 8'd0, 8'd10, 8'd0, SECTOR_0, 1'b0}},
		'{ROW_CFG, REG_AMPLITUDE, 8'd0, 8'd255, 1'b0, '0},
		'{ROW_CFG, REG_PRESCALE, 8'd0, 8'd0, 1'b0, '0},
		'{ROW_CFG, REG_POSITION_STEP, 8'd0, 8'd255, 1'b0, '0},
		'{ROW_LOAD, '0, 8'd0, 8'd255, 1'b0, '0},
		'{ROW_LOAD, '0, 8'd255, 8'd255, 1'b0, '0},
		'{ROW_TICK, '0, 8'd0, 8'd0, 1'b1,
			'{8'd8, 8'd254, 8'd10, 8'd0, 8'd8, 8'd254, SECTOR_0, 1'b0}},
		'{ROW_TICK, '0, 8'd0, 8'd0, 1'b0, '0},
		'{ROW_CFG, REG_REVERSE, 8'd0, 8'd1, 1'b0, '0},
		'{ROW_TICK, '0, 8'd0, 8'd0, 1'b0, '0},
		'{ROW_TICK, '0, 8'd0, 8'd0, 1'b0, '0},
		'{ROW_CFG, REG_DEAD_TIME, 8'd0, 8'd0, 1'b0, '0},
		'{ROW_CFG, REG_AMPLITUDE, 8'd0, 8'd0, 1'b0, '0},
		'{ROW_TICK, '0, 8'd0, 8'd0, 1'b1,
			'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, SECTOR_1, 1'b1}},
		'{ROW_CFG, REG_POSITION_STEP, 8'd0, 8'd0, 1'b0, '0},
		'{ROW_CFG, REG_DEAD_TIME, 8'd0, 8'd255, 1'b0, '0},
		'{ROW_CFG, REG_UNMAPPED, 8'd0, 8'h5A, 1'b0, '0},
		'{ROW_CFG, REG_AMPLITUDE, 8'd0, 8'd128, 1'b0, '0},
		'{ROW_TICK, '0, 8'd0, 8'd0, 1'b0, '0},
		'{ROW_LOAD, '0, 8'd251, 8'd200, 1'b0, '0},
		'{ROW_LOAD, '0, 8'd4, 8'd55, 1'b0, '0},
		'{ROW_TICK, '0, 8'd0, 8'd0, 1'b0, '0},
		'{ROW_CFG, REG_PRESCALE, 8'd0, 8'd255, 1'b0, '0},
		'{ROW_CFG, REG_REVERSE, 8'd0, 8'd0, 1'b0, '0},
		'{ROW_TICK, '0, 8'd0, 8'd0, 1'b0, '0}
	};

	function automatic logic [DATA_W-1:0] scale_word(input logic [DATA_W-1:0] idx);
		logic [DATA_W-1:0]   at;
		logic [2*DATA_W-1:0] prod;
		at = shadow_cfg.reverse ? 8'd255 - idx : idx;
		prod = {8'd0, shadow_cfg.amplitude} * {8'd0, sine_mem[at]};
		return prod[2*DATA_W-1:DATA_W];
	endfunction

	function automatic pwm_out_t predict_compare();
		logic [DATA_W-1:0] driven;
		logic [DATA_W-1:0] trailing;
		logic [DATA_W-1:0] ph [3];
		pwm_out_t          r;
		r.commuted = 1'b0;
		tick_cnt = tick_cnt + 8'd1;
		if (tick_cnt >= shadow_cfg.prescale) begin
			pos = pos + shadow_cfg.position_step;
			if (pos < shadow_cfg.position_step) begin
				r.commuted = 1'b1;
				if (shadow_cfg.reverse)
					sect = (sect == SECTOR_0) ? SECTOR_2 : (sect == SECTOR_1) ? SECTOR_0 : SECTOR_1;
				else
					sect = (sect == SECTOR_0) ? SECTOR_1 : (sect == SECTOR_1) ? SECTOR_2 : SECTOR_0;
			end
			tick_cnt = '0;
		end
		driven   = scale_word(pos);
		trailing = scale_word(8'd255 - pos);
		case (sect)
			SECTOR_1: ph = '{trailing, driven, 8'd0};
			SECTOR_2: ph = '{8'd0, trailing, driven};
			default:  ph = '{driven, 8'd0, trailing};
		endcase
		r.a_low  = ph[0];
		r.b_low  = ph[1];
		r.c_low  = ph[2];
		r.a_high = ph[0] + shadow_cfg.dead_time;
		r.b_high = ph[1] + shadow_cfg.dead_time;
		r.c_high = ph[2] + shadow_cfg.dead_time;
		r.sector = sect;
		return r;
	endfunction

	task automatic report(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic push_req(input logic kind, input logic [DATA_W-1:0] idx,
		input logic [DATA_W-1:0] val);
		if (!calm && $urandom_range(0, 99) < 2) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= kind;
		req_ch.table_index <= idx;
		req_ch.table_value <= val;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (compare_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= addr;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (addr)
			REG_DEAD_TIME:     shadow_cfg.dead_time     = data;
			REG_POSITION_STEP: shadow_cfg.position_step = data;
			REG_AMPLITUDE:     shadow_cfg.amplitude     = data;
			REG_PRESCALE:      shadow_cfg.prescale      = data;
			REG_REVERSE:       shadow_cfg.reverse       = data[0];
			default: ;
		endcase
	endtask

	task automatic send_tick();
		compare_q.push_back(predict_compare());
		push_req(REQ_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic send_load(input logic [DATA_W-1:0] idx, input logic [DATA_W-1:0] val);
		sine_mem[idx] = val;
		push_req(REQ_LOAD, idx, val);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (compare_q.size() == 0) begin
				report("result with no pending expectation");
			end else begin
				got_want = compare_q.pop_front();
				check_field("phase_a_high", rsp_ch.phase_a_high, got_want.a_high);
				check_field("phase_a_low", rsp_ch.phase_a_low, got_want.a_low);
				check_field("phase_b_high", rsp_ch.phase_b_high, got_want.b_high);
				check_field("phase_b_low", rsp_ch.phase_b_low, got_want.b_low);
				check_field("phase_c_high", rsp_ch.phase_c_high, got_want.c_high);
				check_field("phase_c_low", rsp_ch.phase_c_low, got_want.c_low);
				check_field("sector", rsp_ch.sector, got_want.sector);
				check_field("commuted", rsp_ch.commuted, got_want.commuted);
			end
		end
		if (stall_left != 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 2) begin
			stall_left = $urandom_range(0, 5);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [DATA_W-1:0] dt;
		logic [DATA_W-1:0] st;
		logic [DATA_W-1:0] am;
		logic [DATA_W-1:0] ps;
		logic              rv;
		int                pick;
		pwm_out_t          exp_row;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_TICK;
		req_ch.table_index <= '0;
		req_ch.table_value <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.addr        <= REG_DEAD_TIME;
		cfg_ch.data        <= '0;
		shadow_cfg = '{RST_DEAD_TIME, RST_POSITION_STEP, RST_AMPLITUDE, RST_PRESCALE,
			RST_REVERSE};
		tick_cnt = '0;
		pos      = '0;
		sect     = SECTOR_0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < TABLE_DEPTH; i++)
			send_load(8'(i), 8'($urandom_range(0, 255)));

		foreach (dir_rows[r]) begin
			case (dir_rows[r].kind)
				ROW_LOAD: send_load(dir_rows[r].index, dir_rows[r].value);
				ROW_CFG:  write_reg(dir_rows[r].addr, dir_rows[r].value);
				default: begin
					exp_row = predict_compare();
					compare_q.push_back(dir_rows[r].typed ? dir_rows[r].want : exp_row);
					push_req(REQ_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end
			endcase
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					dt = 8'd255; st = 8'd255; am = 8'd255; ps = 8'd0; rv = 1'b1;
				end
				1: begin
					dt = 8'd0; st = 8'd0; am = 8'd0; ps = 8'd0; rv = 1'b0;
				end
				default: begin
					dt = 8'($urandom_range(0, 255));
					am = 8'($urandom_range(0, 255));
					rv = 1'($urandom_range(0, 1));
					st = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(200, 255))
						: 8'($urandom_range(0, 255));
					pick = $urandom_range(0, 9);
					if (pick < 6)
						ps = 8'($urandom_range(0, 3));
					else if (pick < 9)
						ps = 8'($urandom_range(4, 15));
					else
						ps = 8'd255;
				end
			endcase
			write_reg(REG_DEAD_TIME, dt);
			write_reg(REG_POSITION_STEP, st);
			write_reg(REG_AMPLITUDE, am);
			write_reg(REG_PRESCALE, ps);
			write_reg(REG_REVERSE, {7'($urandom_range(0, 127)), rv});
			write_reg(REG_UNMAPPED + 3'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
			calm = (ph == 3);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < 15)
					send_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				else
					send_tick();
			end
			calm = 1'b0;
		end

		req_ch.valid <= 1'b0;
		while (compare_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
